/* rtl/ste_pkg.sv */
// shared types and constants for the station table with oldest-entry eviction
// no dependencies; imported by ste_ctrl, ste_dp and station_table_oldest_evict
package ste_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;
    localparam int OUT_CNT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP  = 2'd0,
        KIND_INSERT  = 2'd1,
        KIND_REFRESH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_stat_t;

    // low bits of the entry count as carried on the result
    function automatic logic [OUT_CNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] w;
        w = {{OUT_CNT_W{1'b0}}, c};
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

/* rtl/ste_ctrl.sv */
// controller state machine: accept, scan sequencing, commit and result valid
// depends on ste_pkg
module ste_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ste_pkg::dp_stat_t stat,
    output ste_pkg::dp_cmd_t  cmd
);
    import ste_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/ste_dp.sv */
// datapath: mac and stamp memories, valid bits, scan trackers, count and result
// depends on ste_pkg
module ste_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ste_pkg::dp_cmd_t                 cmd,
    output ste_pkg::dp_stat_t                stat,
    input  logic [ste_pkg::KIND_W-1:0]       s_kind,
    input  logic [ste_pkg::MAC_W-1:0]        s_station_mac,
    input  logic [ste_pkg::TIME_W-1:0]       s_now_time,
    output logic                             m_found,
    output logic                             m_evicted,
    output logic [ste_pkg::OUT_CNT_W-1:0]    m_entry_count
);
    import ste_pkg::*;

    logic [MAC_W-1:0]  mac_mem   [ENTRIES];
    logic [TIME_W-1:0] stamp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [KIND_W-1:0] kind_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [TIME_W-1:0] now_reg;
    logic [IDX_W-1:0]  idx_reg;

    // registered read stage
    logic              rd_en_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_vld_reg;
    logic [MAC_W-1:0]  rd_mac_reg;
    logic [TIME_W-1:0] rd_stamp_reg;

    // scan trackers
    logic              hit_reg, free_reg, old_reg;
    logic [IDX_W-1:0]  hit_idx_reg, free_idx_reg, old_idx_reg;
    logic [TIME_W-1:0] best_reg;

    logic              do_insert, do_evict, do_refresh, wr_en;
    logic [IDX_W-1:0]  wr_idx;

    assign stat.scan_last = (idx_reg == IDX_W'(ENTRIES - 1));

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            kind_reg <= s_kind;
            mac_reg  <= s_station_mac;
            now_reg  <= s_now_time;
            idx_reg  <= '0;
        end else if (cmd.scan) begin
            idx_reg  <= idx_reg + 1'b1;
        end
    end

    // memory read, one entry a cycle
    always_ff @(posedge aclk) begin
        rd_mac_reg   <= mac_mem[idx_reg];
        rd_stamp_reg <= stamp_mem[idx_reg];
        rd_idx_reg   <= idx_reg;
        rd_vld_reg   <= valid_reg[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_en_reg <= 1'b0;
        end else begin
            rd_en_reg <= cmd.scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            old_reg  <= 1'b0;
            best_reg <= s_now_time;
        end else if (rd_en_reg) begin
            if (rd_vld_reg && rd_mac_reg == mac_reg && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= rd_idx_reg;
            end
            if (!rd_vld_reg && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            // strict compare keeps the lowest slot on equal stamps
            if (rd_vld_reg && rd_stamp_reg < best_reg) begin
                old_reg     <= 1'b1;
                old_idx_reg <= rd_idx_reg;
                best_reg    <= rd_stamp_reg;
            end
        end
    end

    always_comb begin
        do_insert  = cmd.commit && kind_reg == KIND_INSERT && !hit_reg && free_reg;
        do_evict   = cmd.commit && kind_reg == KIND_INSERT && !hit_reg && !free_reg
                     && old_reg;
        do_refresh = cmd.commit && kind_reg == KIND_REFRESH && hit_reg;
        wr_en      = do_insert || do_evict || do_refresh;
        wr_idx     = hit_idx_reg;
        if (do_insert) begin
            wr_idx = free_idx_reg;
        end else if (do_evict) begin
            wr_idx = old_idx_reg;
        end
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (do_insert) begin
            valid_next[free_idx_reg] = 1'b1;
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stamp_mem[wr_idx] <= now_reg;
            if (!do_refresh) begin
                mac_mem[wr_idx] <= mac_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_found       <= hit_reg;
            m_evicted     <= do_evict;
            m_entry_count <= count_out(cnt_next);
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

    a_cnt_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(cnt_reg))
        else $error("entry count out of step with valid bits");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> cnt_reg == CNT_W'($past(cnt_reg) + 1'b1))
        else $error("insert into free slot did not grow count");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        do_evict |-> cnt_reg == CNT_W'(ENTRIES))
        else $error("eviction with table not full");

endmodule

/* rtl/station_table_oldest_evict.sv */
// top level of the station table with oldest-entry eviction
// depends on ste_pkg, ste_ctrl and ste_dp
//
//  channel  | direction | ports                                         | handshake
//  ---------+-----------+-----------------------------------------------+----------
//  request  | in        | s_kind, s_station_mac, s_now_time             | s_valid/s_ready
//  result   | out       | m_found, m_evicted, m_entry_count             | m_valid/m_ready
//
// each item is accepted, then scanned slot by slot through the single read port of the
// mac/stamp memories; the registered read then drains, and the commit writes the table
// and loads the result register
// aresetn (synchronous, active low) clears valid bits and the count at once; no sweep
// a result waiting in the output register does not hold off the next item's scan;
// only the commit waits for m_ready when the previous result is still unclaimed
module station_table_oldest_evict (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ste_pkg::KIND_W-1:0]       s_kind,
    input  logic [ste_pkg::MAC_W-1:0]        s_station_mac,
    input  logic [ste_pkg::TIME_W-1:0]       s_now_time,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic                             m_evicted,
    output logic [ste_pkg::OUT_CNT_W-1:0]    m_entry_count
);
    import ste_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: accept, scan, drain, commit
    ste_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table storage, match / free / oldest tracking, result register
    ste_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_kind        (s_kind),
        .s_station_mac (s_station_mac),
        .s_now_time    (s_now_time),
        .m_found       (m_found),
        .m_evicted     (m_evicted),
        .m_entry_count (m_entry_count)
    );

endmodule
